@@ hw/rtl/neighbor_etx_table_unit_defines.svh @@
// Assertion helpers for the neighbor table; clock and reset are the ports of the top level.
`ifndef NEIGHBOR_ETX_TABLE_UNIT_DEFINES_SVH
`define NEIGHBOR_ETX_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NETX_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("neighbor table check failed");

// Next-cycle implication.
`define NETX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("neighbor table check failed");

`endif

@@ hw/rtl/netx_pkg.sv @@
`default_nettype none

package netx_pkg;

   localparam int NEIGHBORS   = 16;
   localparam int IDX_W       = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int ADDR_W      = 64;
   localparam int METRIC_W    = 12;
   localparam int ALPHA_W     = 7;
   localparam int PENALTY_W   = 8;
   localparam int PROD_W      = 19;
   localparam int RECIP_W     = PROD_W + 20;
   localparam int RECIP_SHIFT = 26;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [1:0] CMD_SENT  = 2'd0;
   localparam logic [1:0] CMD_RECV  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] TX_OK    = 2'd0;
   localparam logic [1:0] TX_NOACK = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_NOTIFY_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EWMA_ALPHA    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOACK_PENALTY = 2'd2;

   localparam logic [METRIC_W-1:0]  LIMIT_FIX     = 12'd240;
   localparam logic [ALPHA_W-1:0]   WEIGHT_SCALE  = 7'd100;
   localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 7'd90;
   localparam logic [PENALTY_W-1:0] PENALTY_RESET = 8'd15;
   localparam logic [19:0]          RECIP_MUL     = 20'd671088;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] link_addr;
      logic [1:0]        tx_status;
      logic [7:0]        tx_count;
   } req_word_type;

   typedef struct packed {
      logic [METRIC_W-1:0] metric;
      logic                known;
      logic                stored;
      logic                changed;
      logic                notify;
      logic                added;
      logic                table_full;
      logic                ignored;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic mult;
      logic sum;
      logic recip;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic slow;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/netx_ctrl.sv @@
`default_nettype none

module netx_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire netx_pkg::dp_stat_type dp_stat,
   output netx_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MULT,
      ST_SUM,
      ST_RECIP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      dp_cmd       = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            dp_cmd.lookup = 1'b1;
            state_in      = ST_MULT;
         end
         ST_MULT: begin
            dp_cmd.mult = 1'b1;
            state_in    = dp_stat.slow ? ST_SUM : ST_FINISH;
         end
         ST_SUM: begin
            dp_cmd.sum = 1'b1;
            state_in   = ST_RECIP;
         end
         ST_RECIP: begin
            dp_cmd.recip = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.finish = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hw/rtl/netx_dpath.sv @@
`default_nettype none

module netx_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [netx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [netx_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire netx_pkg::req_word_type              req_data,
   input  wire netx_pkg::dp_cmd_type                dp_cmd,
   output netx_pkg::dp_stat_type                    dp_stat,
   output netx_pkg::rsp_word_type                   rsp_data
);

   logic                               notify_en_ff;
   logic [netx_pkg::ALPHA_W-1:0]       alpha_ff;
   logic [netx_pkg::PENALTY_W-1:0]     penalty_ff;

   logic [netx_pkg::NEIGHBORS-1:0]     valid_ff;
   logic [netx_pkg::ADDR_W-1:0]        addr_ff   [netx_pkg::NEIGHBORS];
   logic [netx_pkg::METRIC_W-1:0]      metric_ff [netx_pkg::NEIGHBORS];

   netx_pkg::req_word_type             item_ff;
   netx_pkg::rsp_word_type             rsp_ff;
   netx_pkg::rsp_word_type             rsp_in;

   logic [netx_pkg::NEIGHBORS-1:0]     match;
   logic                               hit_ff, hit_in;
   logic [netx_pkg::IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic                               free_ff, free_in;
   logic [netx_pkg::IDX_W-1:0]         free_idx_ff, free_idx_in;

   logic                               ignore;
   logic                               is_sent;
   logic                               add_mode;
   logic [netx_pkg::ALPHA_W-1:0]       alpha_c;
   logic [netx_pkg::METRIC_W-1:0]      old_ff, old_in;
   logic [netx_pkg::METRIC_W-1:0]      sample_ff, sample_in;
   logic                               slot_ok_ff, slot_ok_in;
   logic [netx_pkg::IDX_W-1:0]         slot_idx_ff, slot_idx_in;
   logic                               added_ff, added_in;
   logic                               full_ff, full_in;
   logic                               slow_ff, slow_in;
   logic [netx_pkg::PROD_W-1:0]        prod_a_ff, prod_a_in;
   logic [netx_pkg::PROD_W-1:0]        prod_b_ff, prod_b_in;
   logic [netx_pkg::PROD_W-1:0]        num_ff, num_in;
   logic [netx_pkg::RECIP_W-1:0]       recip_prod;
   logic [netx_pkg::METRIC_W-1:0]      q0_ff, q0_in;
   logic [netx_pkg::PROD_W-1:0]        rem;
   logic [netx_pkg::METRIC_W-1:0]      fresh_slow;
   logic [netx_pkg::METRIC_W-1:0]      fresh;
   logic [netx_pkg::METRIC_W-1:0]      recorded;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         notify_en_ff <= 1'b0;
         alpha_ff     <= netx_pkg::ALPHA_RESET;
         penalty_ff   <= netx_pkg::PENALTY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            netx_pkg::CSR_NOTIFY_ENABLE: notify_en_ff <= csr_wdata[0];
            netx_pkg::CSR_EWMA_ALPHA:    alpha_ff     <= csr_wdata[netx_pkg::ALPHA_W-1:0];
            netx_pkg::CSR_NOACK_PENALTY: penalty_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign is_sent  = (item_ff.cmd == netx_pkg::CMD_SENT);
   assign ignore   = (item_ff.link_addr == '0)
                  || ((item_ff.cmd != netx_pkg::CMD_SENT)
                      && (item_ff.cmd != netx_pkg::CMD_RECV)
                      && (item_ff.cmd != netx_pkg::CMD_QUERY))
                  || (is_sent && (item_ff.tx_status != netx_pkg::TX_OK)
                      && (item_ff.tx_status != netx_pkg::TX_NOACK));
   assign add_mode = !ignore && ((item_ff.cmd == netx_pkg::CMD_RECV)
                  || (is_sent && (item_ff.tx_status == netx_pkg::TX_OK)));

   // lookup: parallel compare, lowest matching and lowest free entry
   always_comb begin
      hit_idx_in  = '0;
      free_idx_in = '0;
      for (int i = 0; i < netx_pkg::NEIGHBORS; i++) begin
         match[i] = valid_ff[i] && (addr_ff[i] == item_ff.link_addr);
      end
      for (int i = netx_pkg::NEIGHBORS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx_in = netx_pkg::IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx_in = netx_pkg::IDX_W'(i);
         end
      end
      hit_in  = |match;
      free_in = ~&valid_ff;
   end

   // slot resolve and products
   always_comb begin
      old_in      = hit_ff ? metric_ff[hit_idx_ff] : '0;
      slot_ok_in  = !ignore && (hit_ff || (add_mode && free_ff));
      slot_idx_in = hit_ff ? hit_idx_ff : free_idx_ff;
      added_in    = add_mode && !hit_ff && free_ff;
      full_in     = add_mode && !hit_ff && !free_ff;
      sample_in   = (item_ff.tx_status == netx_pkg::TX_OK)
                  ? {item_ff.tx_count, 4'b0000} : {penalty_ff, 4'b0000};
      slow_in     = !ignore && is_sent && hit_ff && (old_in != '0);
      alpha_c     = (alpha_ff > netx_pkg::WEIGHT_SCALE) ? netx_pkg::WEIGHT_SCALE : alpha_ff;
      prod_a_in   = netx_pkg::PROD_W'(old_in) * netx_pkg::PROD_W'(alpha_c);
      prod_b_in   = netx_pkg::PROD_W'(sample_in)
                  * netx_pkg::PROD_W'(netx_pkg::WEIGHT_SCALE - alpha_c);
   end

   assign dp_stat.slow = slow_in;

   // divide by 100: reciprocal estimate, then one correction step
   assign num_in     = prod_a_ff + prod_b_ff;
   assign recip_prod = netx_pkg::RECIP_W'(num_ff) * netx_pkg::RECIP_W'(netx_pkg::RECIP_MUL);
   assign q0_in      = recip_prod[netx_pkg::RECIP_SHIFT +: netx_pkg::METRIC_W];
   assign rem        = num_ff
                     - netx_pkg::PROD_W'(q0_ff) * netx_pkg::PROD_W'(netx_pkg::WEIGHT_SCALE);
   assign fresh_slow = (rem >= netx_pkg::PROD_W'(netx_pkg::WEIGHT_SCALE))
                     ? q0_ff + netx_pkg::METRIC_W'(1) : q0_ff;
   assign fresh      = slow_ff ? fresh_slow : sample_ff;
   assign recorded   = slow_ff ? old_ff : netx_pkg::LIMIT_FIX;

   always_comb begin
      rsp_in = '0;
      if (ignore) begin
         rsp_in.ignored = 1'b1;
      end else begin
         case (item_ff.cmd)
            netx_pkg::CMD_QUERY, netx_pkg::CMD_RECV: begin
               rsp_in.metric     = slot_ok_ff ? old_ff : netx_pkg::LIMIT_FIX;
               rsp_in.known      = slot_ok_ff;
               rsp_in.added      = added_ff;
               rsp_in.table_full = full_ff;
            end
            netx_pkg::CMD_SENT: begin
               rsp_in.metric     = fresh;
               rsp_in.known      = slot_ok_ff;
               rsp_in.added      = added_ff;
               rsp_in.table_full = full_ff;
               rsp_in.stored     = slot_ok_ff;
               rsp_in.changed    = slot_ok_ff && (fresh != recorded);
               rsp_in.notify     = slot_ok_ff && notify_en_ff;
            end
            default: begin
               rsp_in.ignored = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         item_ff <= req_data;
      end
      if (dp_cmd.lookup) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         free_ff     <= free_in;
         free_idx_ff <= free_idx_in;
      end
      if (dp_cmd.mult) begin
         old_ff      <= old_in;
         sample_ff   <= sample_in;
         slot_ok_ff  <= slot_ok_in;
         slot_idx_ff <= slot_idx_in;
         added_ff    <= added_in;
         full_ff     <= full_in;
         slow_ff     <= slow_in;
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
      end
      if (dp_cmd.sum) begin
         num_ff <= num_in;
      end
      if (dp_cmd.recip) begin
         q0_ff <= q0_in;
      end
      if (dp_cmd.finish) begin
         rsp_ff <= rsp_in;
         if (added_ff) begin
            addr_ff[slot_idx_ff] <= item_ff.link_addr;
         end
         if (added_ff || (is_sent && slot_ok_ff)) begin
            metric_ff[slot_idx_ff] <= is_sent ? fresh : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (dp_cmd.finish && added_ff) begin
         valid_ff[slot_idx_ff] <= 1'b1;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/neighbor_etx_table_unit.sv @@
// Neighbor ETX table: a 16-entry table of 64-bit link addresses with ETX metrics
// in 1/16 units, averaged with a programmable weight.
// Input channel req_*: one word per command (sent, received, query); the unit takes
// one word at a time and holds req_stall high until that word has moved to the
// output register.
// Result channel rsp_*: exactly one word per accepted command, in order.
// Steps: a query, a received event or a sent event without an average passes lookup,
// multiply and finish; a sent event that averages also passes the sum and the
// reciprocal multiply of the divide by 100, all walked by the sequencer on one
// shared datapath. A new word is taken only once the last one has reached the
// output register.
// A finished word waits in the output register while rsp_stall is high; the next
// word is accepted meanwhile and runs up to its final step, where it holds.
// Configuration via csr_*: write only while idle. Reset empties the table and
// restores the register defaults (alpha 90, penalty 15, notifications off).

`default_nettype none

`include "neighbor_etx_table_unit_defines.svh"

module neighbor_etx_table_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [netx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [netx_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire netx_pkg::req_word_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output netx_pkg::rsp_word_type               rsp_data
);

   netx_pkg::dp_cmd_type  dp_cmd;
   netx_pkg::dp_stat_type dp_stat;

   netx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   netx_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_data  (rsp_data)
   );

   `NETX_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `NETX_ASSERT_NEXT(a_finish_gives_word, dp_cmd.finish, rsp_valid)
   `NETX_ASSERT_NOW(a_no_overwrite, dp_cmd.finish, !(rsp_valid && rsp_stall))
   `NETX_ASSERT_NOW(a_one_step, 1'b1, $onehot0(dp_cmd))

endmodule

`default_nettype wire
